// File: rtl/cls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cramer solver package
// Word types, command word between front and back, permutation table.
// ----------------------------------------------------------------------------
package cls_pkg;

    localparam int MAX_ORDER_DEF     = 4;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int VALUE_W           = 32;
    localparam int PERM_COUNT        = 24;
    localparam logic [2:0] ORDER_RESET = 3'd3;

    typedef struct packed {
        logic [1:0]         row_index;
        logic [2:0]         column_index;
        logic signed [31:0] entry_value;
        logic               final_entry;
    } item_t;

    typedef struct packed {
        logic [1:0]         unknown_index;
        logic signed [31:0] solution_value;
        logic               singular;
        logic               saturated;
        logic               last_result;
    } result_t;

    typedef struct packed {
        logic        store_en;
        logic [1:0]  row_index;
        logic [2:0]  column_index;
        logic [31:0] entry_value;
        logic        solve_en;
        logic [2:0]  order_n;
    } cmd_t;

    // column taken in each row, row r in bits [2r+1:2r]
    localparam logic [7:0] PERM_TBL [PERM_COUNT] = '{
        8'b11_10_01_00, 8'b10_11_01_00, 8'b11_01_10_00, 8'b01_11_10_00,
        8'b10_01_11_00, 8'b01_10_11_00, 8'b11_10_00_01, 8'b10_11_00_01,
        8'b11_00_10_01, 8'b00_11_10_01, 8'b10_00_11_01, 8'b00_10_11_01,
        8'b11_01_00_10, 8'b01_11_00_10, 8'b11_00_01_10, 8'b00_11_01_10,
        8'b01_00_11_10, 8'b00_01_11_10, 8'b10_01_00_11, 8'b01_10_00_11,
        8'b10_00_01_11, 8'b00_10_01_11, 8'b01_00_10_11, 8'b00_01_10_11
    };

    function automatic logic [1:0] perm_col(input logic [4:0] p, input logic [1:0] r);
        logic [7:0] w;
        w = PERM_TBL[p];
        return w[2*r +: 2];
    endfunction

    function automatic logic perm_odd(input logic [4:0] p);
        return p[0] ^ p[1];
    endfunction

    function automatic logic perm_fits(input logic [4:0] p, input logic [2:0] n);
        logic ok;
        ok = 1'b1;
        for (int r = 0; r < 4; r++)
        begin
            if (r >= int'(n) && perm_col(p, 2'(r)) != 2'(r))
                ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

// File: rtl/cls_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cramer solver front end
// Holds the order register, accepts entry words and classifies them.
// ----------------------------------------------------------------------------
module cls_front #(
    parameter int MAX_ORDER = cls_pkg::MAX_ORDER_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cls_pkg::item_t   item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_data,
    input  logic             queue_full,
    output logic             push,
    output cls_pkg::cmd_t    cmd
);

    logic [2:0] order_reg;
    logic [2:0] order_n;

    assign cfg_ready = 1'b1;
    assign busy      = queue_full;
    assign push      = start & ~queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= cls_pkg::ORDER_RESET;
        else if (cfg_valid && cfg_ready)
            order_reg <= cfg_data;
    end

    always_comb
    begin
        if (order_reg == 3'd0)
            order_n = 3'd1;
        else if (int'(order_reg) > MAX_ORDER)
            order_n = 3'(MAX_ORDER);
        else
            order_n = order_reg;
    end

    always_comb
    begin
        cmd.store_en     = (int'(item.row_index) < MAX_ORDER) &&
                           (int'(item.column_index) <= MAX_ORDER);
        cmd.row_index    = item.row_index;
        cmd.column_index = item.column_index;
        cmd.entry_value  = item.entry_value;
        cmd.solve_en     = item.final_entry;
        cmd.order_n      = order_n;
    end

endmodule

// File: rtl/cls_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cramer solver command queue
// Two-entry queue of command words between front and back.
// ----------------------------------------------------------------------------
module cls_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cls_pkg::cmd_t cmd_in,
    input  logic          pop,
    output cls_pkg::cmd_t cmd_out,
    output logic          empty,
    output logic          full
);

    cls_pkg::cmd_t slot [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign cmd_out = slot[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot[wr_ptr_reg] <= cmd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// File: rtl/cls_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cramer solver back end
// Entry store, permutation-sum determinants, bit-serial multiply and divide.
// ----------------------------------------------------------------------------
module cls_back #(
    parameter int MAX_ORDER     = cls_pkg::MAX_ORDER_DEF,
    parameter int FRACTION_BITS = cls_pkg::FRACTION_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  cls_pkg::cmd_t    cmd,
    output logic             pop,
    output logic             result_valid,
    output cls_pkg::result_t result
);

    localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = 32 * MAX_ORDER;
    localparam int DW    = PW + 8;
    localparam int NB    = DW + FRACTION_BITS;
    localparam int CW    = $clog2(NB + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PERM, S_READ, S_LOAD, S_MUL, S_ACC, S_DET, S_DIV, S_OUT
    } state_t;

    state_t           state_reg;
    logic [31:0]      mem [DEPTH];
    logic [31:0]      rd_reg;
    logic [2:0]       n_reg;
    logic [2:0]       repl_reg;
    logic [4:0]       perm_reg;
    logic [2:0]       r_reg;
    logic [1:0]       unk_reg;
    logic             psign_reg;
    logic [PW-1:0]    prod_reg;
    logic [PW-1:0]    acc_reg;
    logic [PW-1:0]    mc_reg;
    logic [31:0]      m_reg;
    logic [DW-1:0]    det_reg;
    logic [DW-1:0]    dmag_reg;
    logic             dneg_reg;
    logic             qneg_reg;
    logic [NB-1:0]    num_reg;
    logic [NB-1:0]    q_reg;
    logic [DW-1:0]    rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic             result_valid_reg;
    cls_pkg::result_t result_reg;

    logic [1:0]    rcol;
    logic [2:0]    col_sel;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic [DW-1:0] prod_ext;
    logic [DW-1:0] abs_det;
    logic [DW:0]   trial;
    logic          ge;
    logic [31:0]   limit;
    logic          sat;
    logic          neg_res;
    logic [31:0]   res;
    logic          last;

    assign pop          = (state_reg == S_IDLE) && !empty;
    assign wr_en        = pop && cmd.store_en;
    assign wr_addr      = AW'(int'(cmd.row_index) * (MAX_ORDER + 1) + int'(cmd.column_index));
    assign rcol         = cls_pkg::perm_col(perm_reg, r_reg[1:0]);
    assign col_sel      = ({1'b0, rcol} == repl_reg) ? 3'(MAX_ORDER) : {1'b0, rcol};
    assign rd_addr      = AW'(int'(r_reg[1:0]) * (MAX_ORDER + 1) + int'(col_sel));
    assign prod_ext     = DW'(prod_reg);
    assign abs_det      = det_reg[DW-1] ? (~det_reg + DW'(1)) : det_reg;
    assign trial        = {rem_reg, num_reg[NB-1]};
    assign ge           = trial >= {1'b0, dmag_reg};
    assign limit        = qneg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign sat          = (|q_reg[NB-1:32]) || (q_reg[31:0] > limit);
    assign neg_res      = qneg_reg && (q_reg != '0);
    assign res          = sat ? limit : (neg_res ? (~q_reg[31:0] + 32'd1) : q_reg[31:0]);
    assign last         = ({1'b0, unk_reg} + 3'd1) == n_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= cmd.entry_value;
        if (state_reg == S_READ)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            n_reg            <= 3'd1;
            repl_reg         <= 3'd0;
            perm_reg         <= 5'd0;
            r_reg            <= 3'd0;
            unk_reg          <= 2'd0;
            cnt_reg          <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (pop && cmd.solve_en)
                    begin
                        n_reg     <= cmd.order_n;
                        repl_reg  <= 3'(MAX_ORDER);
                        det_reg   <= '0;
                        perm_reg  <= 5'd0;
                        state_reg <= S_PERM;
                    end
                end
                S_PERM:
                begin
                    if (cls_pkg::perm_fits(perm_reg, n_reg))
                    begin
                        prod_reg  <= PW'(1);
                        psign_reg <= cls_pkg::perm_odd(perm_reg);
                        r_reg     <= 3'd0;
                        state_reg <= S_READ;
                    end
                    else if (perm_reg == 5'(cls_pkg::PERM_COUNT - 1))
                        state_reg <= S_DET;
                    else
                        perm_reg <= perm_reg + 5'd1;
                end
                S_READ:
                    state_reg <= S_LOAD;
                S_LOAD:
                begin
                    m_reg     <= rd_reg[31] ? (~rd_reg + 32'd1) : rd_reg;
                    psign_reg <= psign_reg ^ rd_reg[31];
                    acc_reg   <= '0;
                    mc_reg    <= prod_reg;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (m_reg == 32'd0)
                    begin
                        prod_reg <= acc_reg;
                        if ((r_reg + 3'd1) == n_reg)
                            state_reg <= S_ACC;
                        else
                        begin
                            r_reg     <= r_reg + 3'd1;
                            state_reg <= S_READ;
                        end
                    end
                    else
                    begin
                        if (m_reg[0])
                            acc_reg <= acc_reg + mc_reg;
                        mc_reg <= mc_reg << 1;
                        m_reg  <= m_reg >> 1;
                    end
                end
                S_ACC:
                begin
                    det_reg <= psign_reg ? (det_reg - prod_ext) : (det_reg + prod_ext);
                    if (perm_reg == 5'(cls_pkg::PERM_COUNT - 1))
                        state_reg <= S_DET;
                    else
                    begin
                        perm_reg  <= perm_reg + 5'd1;
                        state_reg <= S_PERM;
                    end
                end
                S_DET:
                begin
                    if (repl_reg == 3'(MAX_ORDER))
                    begin
                        if (det_reg == '0)
                        begin
                            result_reg.unknown_index  <= 2'd0;
                            result_reg.solution_value <= '0;
                            result_reg.singular       <= 1'b1;
                            result_reg.saturated      <= 1'b0;
                            result_reg.last_result    <= 1'b1;
                            result_valid_reg          <= 1'b1;
                            state_reg                 <= S_IDLE;
                        end
                        else
                        begin
                            dmag_reg  <= abs_det;
                            dneg_reg  <= det_reg[DW-1];
                            unk_reg   <= 2'd0;
                            repl_reg  <= 3'd0;
                            det_reg   <= '0;
                            perm_reg  <= 5'd0;
                            state_reg <= S_PERM;
                        end
                    end
                    else
                    begin
                        qneg_reg  <= det_reg[DW-1] ^ dneg_reg;
                        num_reg   <= {abs_det, {FRACTION_BITS{1'b0}}};
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        cnt_reg   <= CW'(NB);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= ge ? DW'(trial - {1'b0, dmag_reg}) : trial[DW-1:0];
                    q_reg   <= {q_reg[NB-2:0], ge};
                    num_reg <= num_reg << 1;
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    result_reg.unknown_index  <= unk_reg;
                    result_reg.solution_value <= res;
                    result_reg.singular       <= 1'b0;
                    result_reg.saturated      <= sat;
                    result_reg.last_result    <= last;
                    result_valid_reg          <= 1'b1;
                    if (last)
                        state_reg <= S_IDLE;
                    else
                    begin
                        unk_reg   <= unk_reg + 2'd1;
                        repl_reg  <= {1'b0, unk_reg} + 3'd1;
                        det_reg   <= '0;
                        perm_reg  <= 5'd0;
                        state_reg <= S_PERM;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/cramer_linear_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cramer linear solver
// Loads an order-n system word by word and emits x_i in fixed point.
// ----------------------------------------------------------------------------
// An entry word is accepted at any edge where start is high and busy is low;
// busy rises only when the two-word command queue is full. A word with
// final_entry set starts a solve of n+1 determinants, each summed over the 24
// permutation slots of a 4x4 matrix: for each of the n! terms that fit the
// order, each of the n factors is read from the store and multiplied in by
// shift-add, then the term is accumulated, and each determinant is closed in
// its own state. Each of the n divisions then runs in a restoring divider,
// followed by an output state. The solve time is set by the order and the bit
// length of the entries. Results appear on result for one cycle with
// result_valid high and cannot be held off; a singular system yields a single
// word.
// ----------------------------------------------------------------------------
module cramer_linear_solver #(
    parameter int MAX_ORDER     = cls_pkg::MAX_ORDER_DEF,
    parameter int FRACTION_BITS = cls_pkg::FRACTION_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cls_pkg::item_t   item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_data,
    output logic             result_valid,
    output cls_pkg::result_t result
);

    cls_pkg::cmd_t push_cmd;
    cls_pkg::cmd_t pop_cmd;
    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;

    cls_front #(
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .queue_full (q_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    cls_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (push_cmd),
        .pop     (pop),
        .cmd_out (pop_cmd),
        .empty   (q_empty),
        .full    (q_full)
    );

    cls_back #(
        .MAX_ORDER     (MAX_ORDER),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (q_empty),
        .cmd          (pop_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// File: tb/sv/cramer_linear_solver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cramer linear solver testbench
// Loads linear systems entry by entry, predicts every solution word with an
// exact wide-integer determinant and division, and checks each result word
// in order. Covers all orders, singular systems, saturation and ignored
// out-of-range entries under random start gaps.
// ----------------------------------------------------------------------------
module cramer_linear_solver_tb;

    localparam int NMAX      = 4;
    localparam int FRAC      = 16;
    localparam int CYCLE_CAP = 3000000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cls_pkg::item_t   item;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [2:0]       cfg_data;
    logic             result_valid;
    cls_pkg::result_t result;

    cramer_linear_solver dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .result_valid(result_valid), .result(result)
    );

    logic signed [31:0] coef_mem [NMAX*NMAX];
    logic signed [31:0] rhs_mem [NMAX];
    logic [2:0]         order_reg;
    cls_pkg::item_t     entry_queue [$];
    cls_pkg::result_t   solution_queue [$];
    int                 mismatches;
    int                 send_idle_pct;
    int                 cycles;
    logic               cfg_req;
    logic [2:0]         cfg_word;
    logic               cfg_done;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic signed [191:0] cell_value(int r, int c, int repl);
        if (c == repl)
            return 192'(rhs_mem[r]);
        return 192'(coef_mem[r*NMAX + c]);
    endfunction

    function automatic logic signed [191:0] minor_det(int row, int mask, int n, int repl);
        logic signed [191:0] acc;
        int pos;
        acc = 0;
        pos = 0;
        if (row + 1 >= n)
        begin
            for (int c = 0; c < n; c++)
                if (mask[c])
                    return cell_value(row, c, repl);
            return 0;
        end
        for (int c = 0; c < n; c++)
        begin
            if (mask[c])
            begin
                if (pos % 2 == 1)
                    acc = acc - minor_det(row + 1, mask & ~(1 << c), n, repl)
                                * cell_value(row, c, repl);
                else
                    acc = acc + minor_det(row + 1, mask & ~(1 << c), n, repl)
                                * cell_value(row, c, repl);
                pos++;
            end
        end
        return acc;
    endfunction

    task automatic solve_system(cls_pkg::item_t it);
        int n;
        int mask;
        logic signed [191:0] dmain;
        logic signed [191:0] di;
        logic [191:0] dmag;
        logic [191:0] q;
        logic neg;
        logic sat;
        logic [31:0] lim;
        cls_pkg::result_t r;
        if (it.row_index < NMAX)
        begin
            if (it.column_index < NMAX)
                coef_mem[it.row_index*NMAX + it.column_index] = it.entry_value;
            else if (it.column_index == NMAX)
                rhs_mem[it.row_index] = it.entry_value;
        end
        if (!it.final_entry)
            return;
        n = order_reg;
        if (n < 1) n = 1;
        if (n > NMAX) n = NMAX;
        mask = (1 << n) - 1;
        dmain = minor_det(0, mask, n, NMAX);
        if (dmain == 0)
        begin
            r = '0;
            r.singular = 1'b1;
            r.last_result = 1'b1;
            solution_queue.push_back(r);
            return;
        end
        dmag = dmain < 0 ? -dmain : dmain;
        for (int i = 0; i < n; i++)
        begin
            di = minor_det(0, mask, n, i);
            neg = (di < 0) != (dmain < 0);
            q = ((di < 0 ? -di : di) << FRAC) / dmag;
            lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            sat = (q > {160'd0, lim});
            if (q == 0) neg = 1'b0;
            r = '0;
            r.unknown_index = 2'(i);
            r.solution_value = sat ? lim : (neg ? -q[31:0] : q[31:0]);
            r.saturated = sat;
            r.last_result = (i + 1 == n);
            solution_queue.push_back(r);
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
        end
        else if (!start || !busy)
        begin
            if (entry_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item <= entry_queue[0];
                solve_system(entry_queue.pop_front());
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // configuration channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_data <= '0;
            cfg_done <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_valid <= 1'b0;
            cfg_done <= 1'b1;
        end
        else if (cfg_req && !cfg_valid && !cfg_done)
        begin
            cfg_valid <= 1'b1;
            cfg_data <= cfg_word;
        end
        else if (!cfg_req)
            cfg_done <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && result_valid)
        begin
            if (solution_queue.size() == 0)
                report_mismatch("unexpected result word", result.solution_value, 32'd0);
            else
            begin
                cls_pkg::result_t e;
                e = solution_queue.pop_front();
                if (result.unknown_index != e.unknown_index)
                    report_mismatch("unknown_index", 32'(result.unknown_index),
                                    32'(e.unknown_index));
                if (result.solution_value != e.solution_value)
                    report_mismatch("solution_value", result.solution_value,
                                    e.solution_value);
                if (result.singular != e.singular)
                    report_mismatch("singular", 32'(result.singular), 32'(e.singular));
                if (result.saturated != e.saturated)
                    report_mismatch("saturated", 32'(result.saturated), 32'(e.saturated));
                if (result.last_result != e.last_result)
                    report_mismatch("last_result", 32'(result.last_result),
                                    32'(e.last_result));
            end
        end
        if (cycles > CYCLE_CAP)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_value(int kind);
        case (kind)
            0: return 32'($urandom);
            1: return 32'($signed($urandom_range(8, 0)) - 4) <<< 16;
            2: return 32'($urandom_range(32'h7FFFF)) - 32'h40000;
            default: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic cls_pkg::item_t make_entry(int r, int c, logic signed [31:0] v,
                                                  logic f);
        cls_pkg::item_t it;
        it.row_index = 2'(r);
        it.column_index = 3'(c);
        it.entry_value = v;
        it.final_entry = f;
        return it;
    endfunction

    // full system of order n; random kind per system
    task automatic queue_system(int n, int kind);
        int last_r;
        int last_c;
        last_r = $urandom_range(n - 1);
        last_c = $urandom_range(1) ? NMAX : $urandom_range(n - 1);
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= NMAX; c++)
                if ((c < n || c == NMAX) && !(r == last_r && c == last_c))
                begin
                    if ($urandom_range(19) == 0)
                        entry_queue.push_back(make_entry($urandom_range(3),
                                              $urandom_range(7, 5), $urandom, 1'b0));
                    entry_queue.push_back(make_entry(r, c, rand_value(kind), 1'b0));
                end
        entry_queue.push_back(make_entry(last_r, last_c, rand_value(kind), 1'b1));
    endtask

    task automatic drain_and_idle();
        while (entry_queue.size() > 0 || start)
            @(posedge clk);
        while (solution_queue.size() > 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);
    endtask

    task automatic write_order(logic [2:0] v);
        cfg_word = v;
        cfg_req = 1'b1;
        @(posedge clk);
        while (!cfg_done)
            @(posedge clk);
        cfg_req = 1'b0;
        @(posedge clk);
        @(posedge clk);
        order_reg = v;
    endtask

    initial
    begin
        int sent;
        int n;
        logic [2:0] orders [8];
        mismatches = 0;
        cycles = 0;
        cfg_req = 1'b0;
        cfg_word = '0;
        send_idle_pct = 20;
        order_reg = cls_pkg::ORDER_RESET;
        for (int k = 0; k < NMAX*NMAX; k++) coef_mem[k] = 0;
        for (int k = 0; k < NMAX; k++) rhs_mem[k] = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset order 3, identity, singular, saturation
        for (int r = 0; r < 3; r++)
            for (int c = 0; c <= NMAX; c++)
                if (c < 3 || c == NMAX)
                    entry_queue.push_back(make_entry(r, c,
                        (c == r) ? 32'h0001_0000 : (c == NMAX ? 32'h7FFF_FFFF : 32'h0),
                        (r == 2 && c == NMAX)));
        entry_queue.push_back(make_entry(3, 4, 32'h8000_0000, 1'b0));
        entry_queue.push_back(make_entry(1, 7, 32'hFFFF_FFFF, 1'b0));
        entry_queue.push_back(make_entry(0, 0, 32'h0000_0001, 1'b1));
        entry_queue.push_back(make_entry(0, 0, 32'h0, 1'b1));
        entry_queue.push_back(make_entry(0, 5, 32'h1234_5678, 1'b1));
        drain_and_idle();

        orders = '{3'd1, 3'd4, 3'd0, 3'd2, 3'd7, 3'd4, 3'd3, 3'd5};
        sent = 0;
        for (int ph = 0; sent < 270; ph++)
        begin
            send_idle_pct = (ph % 3 == 0) ? 20 : ((ph % 3 == 1) ? 70 : 0);
            write_order(orders[ph % 8]);
            n = orders[ph % 8];
            if (n < 1) n = 1;
            if (n > NMAX) n = NMAX;
            for (int s = 0; s < 4; s++)
                queue_system(n, $urandom_range(3));
            sent += entry_queue.size();
            drain_and_idle();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
